>>> sv/blphi_pkg.sv
package blphi_pkg;
    localparam int LEVEL_W = 12;
    localparam logic signed [11:0] LEVEL_MIN = -12'sd1280;
    localparam logic signed [11:0] LEVEL_MAX = 12'sd0;
    localparam logic signed [11:0] FLOOR_MIN = -12'sd1280;
    localparam logic signed [11:0] FLOOR_MAX = -12'sd310;
    localparam logic signed [11:0] FLOOR_RESET = -12'sd1000;
    localparam logic signed [11:0] CEIL_LEVEL = -12'sd300;
    localparam int MAX_BANDS = 8;

    typedef logic signed [LEVEL_W-1:0] level_t;
endpackage

>>> sv/blphi_div.sv
module blphi_div (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [11:0] num,
    input  logic [11:0] den,
    output logic done,
    output logic [16:0] quo
);
    import blphi_pkg::*;
    // restoring divide of num<<16 by den, one bit per cycle, num < den
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [12:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [27:0] sh_reg, sh_next;
    logic [11:0] den_reg, den_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    assign done = done_reg;
    assign quo = q_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        sh_next = sh_reg;
        den_next = den_reg;
        done_next = 1'b0;
        trial = {rem_reg[11:0], sh_reg[27]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd28;
            rem_next = '0;
            q_next = '0;
            sh_next = {num, 16'd0};
            den_next = den;
        end
        else if (busy_reg)
        begin
            sh_next = {sh_reg[26:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        sh_reg <= sh_next;
        den_reg <= den_next;
    end
endmodule

>>> sv/blphi_sqrt.sv
module blphi_sqrt (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [32:0] x,
    output logic done,
    output logic [16:0] root
);
    import blphi_pkg::*;
    // bitwise integer root, one result bit per cycle
    logic [33:0] x_reg, x_next;
    logic [33:0] res_reg, res_next;
    logic [33:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] t;

    assign done = done_reg;
    assign root = res_reg[16:0];

    always_comb
    begin
        x_next = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        t = res_reg + bit_reg;
        if (start)
        begin
            x_next = {1'b0, x};
            res_next = '0;
            bit_next = 34'h1 << 32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= t)
            begin
                x_next = x_reg - t;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end
endmodule

>>> sv/band_level_peak_hold_index.sv
// Round-robin band level meter. Each accepted sample becomes the level of the
// current band; every band's peak hold is then updated (rise at once, else
// decay by one tenth of a dB, never below the level) and one result per band
// is sent in ascending order, the last carrying the RMS occupancy index in
// tenths of percent. Levels and peaks sit in one synchronous memory that is
// swept twice per item (update, then readout). Each band's normalization
// runs through a one-bit-per-cycle divider and the index through a bit-serial
// root, and an output stall holds the readout; no new sample is accepted
// until the last result is taken. The memory has a clearing pass over all
// bands after reset before the first item is accepted.
module band_level_peak_hold_index #(
    parameter int NUM_BANDS = 7
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [11:0] sample_level,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [11:0] cfg_data,
    output logic out_valid,
    input  logic out_stall,
    output logic [2:0] band_index,
    output logic signed [11:0] band_level,
    output logic signed [11:0] band_peak,
    output logic [9:0] occupancy_index,
    output logic is_last
);
    import blphi_pkg::*;

    localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [BW-1:0] LAST_BAND = BW'(NUM_BANDS - 1);
    // mean by reciprocal multiply, exact for sums below 2^20
    localparam logic [23:0] MEAN_RECIP = 24'((32'd8388608 + NUM_BANDS - 1) / NUM_BANDS);

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
        S_UPD = 4'd3, S_DIVW = 4'd5, S_MUL = 4'd6, S_MEAN = 4'd7,
        S_SQW = 4'd8, S_ORD = 4'd9, S_OUT = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [BW-1:0] ptr_reg, ptr_next;
    logic [BW-1:0] band_reg, band_next;
    logic signed [11:0] smp_reg, smp_next;
    logic [19:0] sum_reg, sum_next;
    logic [16:0] norm_reg, norm_next;
    logic [9:0] occ_reg, occ_next;
    logic signed [11:0] floor_reg [MAX_BANDS];

    logic [23:0] mem [NUM_BANDS];
    logic [23:0] rd_data;
    logic        we;
    logic [BW-1:0] wa, ra;
    logic [23:0] wd;

    logic signed [11:0] lvl_m, pk_m, lvl_new, pk_new, pk_dec, fl;
    logic signed [12:0] num, den;
    logic div_start, div_done, sq_start, sq_done;
    logic [16:0] quo, root;
    logic [33:0] sqr;
    logic [43:0] mean_prod;
    logic [16:0] mean;
    logic [26:0] occ_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BANDS; i++)
                floor_reg[i] <= FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            floor_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data <= mem[ra];
    end

    assign lvl_m = rd_data[23:12];
    assign pk_m  = rd_data[11:0];

    always_comb
    begin
        lvl_new = (band_reg == ptr_reg) ? smp_reg : lvl_m;
        pk_dec = pk_m - 12'sd1;
        if (lvl_new > pk_m)
            pk_new = lvl_new;
        else if (pk_dec < lvl_new)
            pk_new = lvl_new;
        else
            pk_new = pk_dec;
        fl = floor_reg[band_reg];
        if (fl < FLOOR_MIN)
            fl = FLOOR_MIN;
        else if (fl > FLOOR_MAX)
            fl = FLOOR_MAX;
        num = 13'(lvl_new) - 13'(fl);
        den = 13'(CEIL_LEVEL) - 13'(fl);
    end

    blphi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num[11:0]), .den(den[11:0]), .done(div_done), .quo(quo)
    );

    assign mean_prod = 44'(sum_reg) * 44'(MEAN_RECIP);
    assign mean = mean_prod[39:23];

    blphi_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .x(33'(mean) << 16), .done(sq_done), .root(root)
    );

    assign occ_full = 27'(root) * 27'd1000;

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        band_next = band_reg;
        smp_next = smp_reg;
        sum_next = sum_reg;
        norm_next = norm_reg;
        occ_next = occ_reg;
        we = 1'b0;
        wa = band_reg;
        wd = {lvl_new, pk_new};
        ra = band_reg;
        div_start = 1'b0;
        sq_start = 1'b0;
        sqr = 34'(norm_reg) * 34'(norm_reg);
        unique case (state_reg)
            S_CLR:
            begin
                we = 1'b1;
                wd = {FLOOR_RESET, FLOOR_RESET};
                band_next = band_reg + BW'(1);
                if (band_reg == LAST_BAND)
                begin
                    band_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next = (sample_level < LEVEL_MIN) ? LEVEL_MIN :
                        ((sample_level > LEVEL_MAX) ? LEVEL_MAX : sample_level);
                    band_next = '0;
                    sum_next = '0;
                    state_next = S_RD;
                end
            end
            S_RD: state_next = S_UPD;
            S_UPD:
            begin
                we = 1'b1;
                if (num <= 13'sd0)
                begin
                    norm_next = '0;
                    state_next = S_MUL;
                end
                else if (num >= den)
                begin
                    norm_next = 17'h10000;
                    state_next = S_MUL;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    norm_next = quo;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                sum_next = sum_reg + 20'(sqr[33:16]);
                if (band_reg == LAST_BAND)
                begin
                    if (ptr_reg == LAST_BAND)
                        ptr_next = '0;
                    else
                        ptr_next = ptr_reg + BW'(1);
                    state_next = S_MEAN;
                end
                else
                begin
                    band_next = band_reg + BW'(1);
                    state_next = S_RD;
                end
            end
            S_MEAN:
            begin
                sq_start = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (sq_done)
                begin
                    occ_next = occ_full[25:16];
                    band_next = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (band_reg == LAST_BAND)
                        state_next = S_IDLE;
                    else
                    begin
                        band_next = band_reg + BW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign band_index = 3'(band_reg);
    assign band_level = lvl_m;
    assign band_peak = pk_m;
    assign is_last = (band_reg == LAST_BAND);
    assign occupancy_index = is_last ? occ_reg : 10'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ptr_reg <= '0;
            band_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            band_reg <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        sum_reg <= sum_next;
        norm_reg <= norm_next;
        occ_reg <= occ_next;
    end
endmodule

>>> tb/tb_band_level_peak_hold_index.sv
module tb_band_level_peak_hold_index;
    import blphi_pkg::*;

    localparam int NB = 7;
    localparam int RAND_ITEMS = 260;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] band;
        logic signed [11:0] level;
        logic signed [11:0] peak;
        logic [9:0] occ;
        logic last;
    } band_rpt_t;

    class meter_scoreboard;
        logic signed [11:0] floors[MAX_BANDS];
        int levels[MAX_BANDS];
        int peaks[MAX_BANDS];
        int ptr;
        band_rpt_t pending[$];
        int errors;

        function void clear_state();
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                floors[i] = FLOOR_RESET;
                levels[i] = FLOOR_RESET;
                peaks[i] = FLOOR_RESET;
            end
            ptr = 0;
            errors = 0;
        endfunction

        function void write_floor(int idx, logic [11:0] d);
            if (idx < MAX_BANDS)
                floors[idx] = d;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                longint unsigned t;
                t = r | (64'd1 << b);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        function int unsigned occupancy_of();
            longint unsigned sum, norm, mean;
            int fl, num, den;
            sum = 0;
            for (int i = 0; i < NB; i++)
            begin
                fl = floors[i];
                if (fl < FLOOR_MIN) fl = FLOOR_MIN;
                if (fl > FLOOR_MAX) fl = FLOOR_MAX;
                num = levels[i] - fl;
                den = CEIL_LEVEL - fl;
                if (num <= 0) norm = 0;
                else if (num >= den) norm = 65536;
                else norm = (longint'(num) << 16) / den;
                sum += (norm * norm) >> 16;
            end
            mean = sum / NB;
            return (int_sqrt(mean << 16) * 1000) >> 16;
        endfunction

        function void note_sample(logic signed [11:0] s);
            int v;
            int unsigned occ;
            band_rpt_t r;
            v = s;
            if (v < LEVEL_MIN) v = LEVEL_MIN;
            if (v > LEVEL_MAX) v = LEVEL_MAX;
            if (ptr >= NB) ptr = 0;
            levels[ptr] = v;
            ptr = (ptr + 1) % NB;
            for (int i = 0; i < NB; i++)
            begin
                if (levels[i] > peaks[i]) peaks[i] = levels[i];
                else
                begin
                    peaks[i] -= 1;
                    if (peaks[i] < levels[i]) peaks[i] = levels[i];
                end
            end
            occ = occupancy_of();
            for (int i = 0; i < NB; i++)
            begin
                r.band = 3'(i);
                r.level = 12'(levels[i]);
                r.peak = 12'(peaks[i]);
                r.last = (i == NB - 1);
                r.occ = r.last ? occ[9:0] : 10'd0;
                pending.push_back(r);
            end
        endfunction

        function void check_result(band_rpt_t a);
            band_rpt_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result: actual %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.band !== e.band)
            begin
                $display("%0t band_index exp %0d act %0d", $time, e.band, a.band);
                errors++;
            end
            if (a.level !== e.level)
            begin
                $display("%0t band_level exp %0d act %0d", $time, e.level, a.level);
                errors++;
            end
            if (a.peak !== e.peak)
            begin
                $display("%0t band_peak exp %0d act %0d", $time, e.peak, a.peak);
                errors++;
            end
            if (a.occ !== e.occ)
            begin
                $display("%0t occupancy_index exp %0d act %0d", $time, e.occ, a.occ);
                errors++;
            end
            if (a.last !== e.last)
            begin
                $display("%0t is_last exp %0d act %0d", $time, e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [11:0] sample_level = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = 0;
    logic [11:0] cfg_data = 0;
    logic out_valid;
    logic out_stall = 1;
    logic [2:0] band_index;
    logic signed [11:0] band_level;
    logic signed [11:0] band_peak;
    logic [9:0] occupancy_index;
    logic is_last;

    meter_scoreboard sb;
    int idle_cycles;
    int out_gap;
    int stall_left = 0;

    band_level_peak_hold_index #(.NUM_BANDS(NB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_level(sample_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .band_index(band_index), .band_level(band_level), .band_peak(band_peak),
        .occupancy_index(occupancy_index), .is_last(is_last)
    );

    always #4 clk = ~clk;

    task automatic send_sample(logic signed [11:0] s, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        // valid goes low between the previous item and this one
        @(posedge clk);
        repeat (gap) @(posedge clk);
        in_valid <= 1;
        sample_level <= s;
        do @(posedge clk); while (in_stall);
        sb.note_sample(s);
        in_valid <= 0;
    endtask

    task automatic write_floor(int idx, logic [11:0] d);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= 3'(idx);
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_floor(idx, d);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic rand_floors(int mode);
        for (int i = 0; i < MAX_BANDS; i++)
        begin
            logic [11:0] d;
            case (mode)
                0: d = FLOOR_MIN;
                1: d = FLOOR_MAX;
                2: d = 12'($urandom);
                default: d = 12'($urandom_range(0, 970) - 1280);
            endcase
            write_floor(i, d);
        end
    endtask

    function automatic logic signed [11:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 12'($urandom);
            1: return LEVEL_MIN;
            2: return LEVEL_MAX;
            3: return 12'($urandom_range(0, 40) - 320);
            default: return 12'($urandom_range(0, 1280) - 1280);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result('{band_index, band_level, band_peak,
                                  occupancy_index, is_last});
                out_gap = $urandom_range(0, 12);
                stall_left <= out_gap;
                out_stall <= (out_gap != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= (stall_left > 1);
            end
            else
                out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.clear_state();
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_sample(LEVEL_MIN, 0);
        send_sample(LEVEL_MAX, 0);
        send_sample(12'sh7FF, 1);
        send_sample(12'sh800, 1);
        send_sample(-12'sd1, 0);
        send_sample(-12'sd300, 0);
        send_sample(-12'sd1000, 0);
        send_sample(-12'sd999, 0);
        send_sample(12'sh555, 0);
        send_sample(-12'sd1281, 0);
        drain();
        rand_floors(1);
        write_floor(0, 12'h7FF);
        write_floor(1, 12'h800);
        for (int i = 0; i < 8; i++) send_sample(LEVEL_MAX, 0);
        drain();
        rand_floors(0);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? LEVEL_MIN : -12'sd700, 0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            rand_floors(p == 1 ? 2 : 3);
            for (int i = 0; i < RAND_ITEMS / 4; i++)
                send_sample(rand_level(), ($urandom_range(0, 3) == 0));
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
